### design/route_table_with_expiry_core_assert.svh
// Assertion macros shared by the checker of the route table core.
`ifndef ROUTE_TABLE_WITH_EXPIRY_CORE_ASSERT_SVH
`define ROUTE_TABLE_WITH_EXPIRY_CORE_ASSERT_SVH

// Concurrent assertion on a named clock and active-low reset.
`define RTWE_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define RTWE_ASSERT(lbl, prop, msg) \
    `RTWE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

### design/rtwe_pkg.sv
`timescale 1ns / 1ps

package rtwe_pkg;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_WRITE    = 2'd1,
        OP_REDIRECT = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    localparam int ADDR_W   = 32;
    localparam int EIDX_W   = 8;
    localparam int SLOT_W   = 3;

    localparam logic [ADDR_W-1:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [ADDR_W-1:0] DIFF_INIT = 32'h7fff_ffff;

    // Input request packing.
    localparam int S_OPCODE_LSB = 0;
    localparam int S_DEST_LSB   = 2;
    localparam int S_INDEX_LSB  = 34;
    localparam int S_TARGET_LSB = 42;
    localparam int S_MASK_LSB   = 74;
    localparam int S_GW_LSB     = 106;
    localparam int S_LIFE_LSB   = 138;
    localparam int S_NOW_LSB    = 170;
    localparam int S_TDATA_W    = 208;

    // Result packing.
    localparam int M_HOP_LSB    = 0;
    localparam int M_STATUS_BIT = 32;
    localparam int M_SLOT_LSB   = 33;
    localparam int M_PAD_LSB    = 36;
    localparam int M_TDATA_W    = 40;

endpackage

### design/rtwe_ctrl.sv
`timescale 1ns / 1ps

module rtwe_ctrl
    import rtwe_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 8,
    parameter int STATIC_ENTRIES = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  op_t                              opcode,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             div_busy,
    output ctrl_cmd_t                        cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam bit HAS_DYN = STATIC_ENTRIES < TABLE_ENTRIES;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_DYN = HAS_DYN ? IDX_W'(STATIC_ENTRIES) : '0;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             down_reg, down_next;
    logic             out_valid_reg, out_valid_next;
    logic             scan_last;

    // State, scan counter and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            down_reg      <= down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Lookups walk down to entry zero; redirects and ticks walk up to the top.
    assign scan_last = down_reg ? (cnt_reg == '0) : (cnt_reg == IDX_TOP);

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        down_next   = down_reg;
        cmd.capture = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.commit  = 1'b0;
        s_tready    = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_LOOKUP:
                        begin
                            state_next = ST_SCAN;
                            cnt_next   = IDX_TOP;
                            down_next  = 1'b1;
                        end
                        OP_REDIRECT, OP_TICK:
                        begin
                            state_next = HAS_DYN ? ST_SCAN : ST_FINISH;
                            cnt_next   = IDX_DYN;
                            down_next  = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (down_reg)
                begin
                    cnt_next = cnt_reg - IDX_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // The last read is evaluated here; a redirect also waits for its divide.
                if (!div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign scan_idx = cnt_reg;

endmodule

### design/rtwe_dp.sv
`timescale 1ns / 1ps

module rtwe_dp
    import rtwe_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 8,
    parameter int STATIC_ENTRIES   = 4,
    parameter int TICKS_PER_SECOND = 1000
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ctrl_cmd_t                        cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx,
    input  op_t                              opcode,
    input  logic [ADDR_W-1:0]                dest_addr,
    input  logic [EIDX_W-1:0]                entry_index,
    input  logic [ADDR_W-1:0]                route_target,
    input  logic [ADDR_W-1:0]                route_mask,
    input  logic [ADDR_W-1:0]                gateway_addr,
    input  logic [ADDR_W-1:0]                lifetime_ms,
    input  logic [ADDR_W-1:0]                now_seconds,
    output logic                             div_busy,
    output logic [ADDR_W-1:0]                next_hop,
    output logic                             status,
    output logic [SLOT_W-1:0]                slot_used
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam bit HAS_DYN = STATIC_ENTRIES < TABLE_ENTRIES;
    localparam int STATIC_LIM = HAS_DYN ? STATIC_ENTRIES : TABLE_ENTRIES;
    localparam logic [IDX_W-1:0] IDX_DYN = HAS_DYN ? IDX_W'(STATIC_ENTRIES) : '0;
    localparam int ROW_W = 3 * ADDR_W;

    // Reciprocal of the tick rate: floor(x * REC_M / 2^(32 + REC_SH)) equals
    // floor(x / TICKS_PER_SECOND) for every 32-bit x.
    localparam int REC_SH = $clog2(TICKS_PER_SECOND);
    localparam logic [63:0] REC_NUM = 64'd1 << (ADDR_W + REC_SH);
    localparam logic [ADDR_W:0] REC_M =
        (ADDR_W + 1)'((REC_NUM + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));
    localparam int HALF_W = ADDR_W / 2;
    localparam int PROD_W = HALF_W + ADDR_W + 1;
    localparam int ACC_W  = 2 * ADDR_W + 1;

    // Captured request.
    op_t               op_reg;
    logic [ADDR_W-1:0] dest_reg, target_reg, mask_reg, gw_reg, now_reg;
    logic [EIDX_W-1:0] index_reg;

    // Reciprocal multiplier, one half of the lifetime a cycle.
    logic [1:0]        div_cnt_reg;
    logic [ADDR_W-1:0] life_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [HALF_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [ADDR_W-1:0] div_quot;

    // Route memories and their read side.
    logic [ROW_W-1:0]  tmg_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0] exp_mem [TABLE_ENTRIES];
    logic [ROW_W-1:0]  tmg_rd_reg;
    logic [ADDR_W-1:0] exp_rd_reg;
    logic              wr_rd_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    // Per-entry flags.
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [TABLE_ENTRIES-1:0] written_reg;

    // Scan results.
    logic              hit_reg;
    logic [ADDR_W-1:0] hop_reg;
    logic              inv_found_reg, exp_found_reg;
    logic [IDX_W-1:0]  inv_idx_reg, exp_idx_reg, best_idx_reg;
    logic [ADDR_W-1:0] best_diff_reg;

    // Result register.
    logic [ADDR_W-1:0] next_hop_reg;
    logic              status_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [ADDR_W-1:0] ent_target, ent_mask, ent_gw, diff;
    logic              ent_valid, expired, hit_now, static_ok;
    logic [IDX_W-1:0]  slot_sel, w_addr;
    logic              tmg_we, exp_we;
    logic [ROW_W-1:0]  tmg_wdata;
    logic [ADDR_W-1:0] exp_wdata;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            dest_reg   <= dest_addr;
            index_reg  <= entry_index;
            target_reg <= route_target;
            mask_reg   <= route_mask;
            gw_reg     <= gateway_addr;
            now_reg    <= now_seconds;
        end
    end

    // Lifetime times the reciprocal: low half first, then the high half shifted up.
    assign mul_a    = div_cnt_reg[1] ? life_reg[HALF_W-1:0] : life_reg[ADDR_W-1:HALF_W];
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(REC_M);
    assign div_quot = ADDR_W'(acc_reg >> (ADDR_W + REC_SH));
    assign div_busy = (div_cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.capture && opcode == OP_REDIRECT)
        begin
            div_cnt_reg <= 2'd2;
        end
        else if (div_busy)
        begin
            div_cnt_reg <= div_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            life_reg <= lifetime_ms;
            acc_reg  <= '0;
        end
        else if (div_busy)
        begin
            acc_reg <= div_cnt_reg[1] ? ACC_W'(mul_p)
                                      : acc_reg + {mul_p, {HALF_W{1'b0}}};
        end
    end

    // Entry as read; a never-written row reads as zero.
    assign ent_target = wr_rd_reg ? tmg_rd_reg[3*ADDR_W-1:2*ADDR_W] : '0;
    assign ent_mask   = wr_rd_reg ? tmg_rd_reg[2*ADDR_W-1:ADDR_W] : '0;
    assign ent_gw     = wr_rd_reg ? tmg_rd_reg[ADDR_W-1:0] : '0;
    assign ent_valid  = entry_valid_reg[rd_idx_reg];

    // Wrapping difference of expiry and now; zero or negative means expired.
    assign diff    = exp_rd_reg - now_reg;
    assign expired = (diff == '0) || diff[ADDR_W-1];

    assign hit_now = rd_vld_reg && (op_reg == OP_LOOKUP) && !hit_reg && ent_valid
                     && ((dest_reg & ent_mask) == ent_target);

    // Write side for a static write or a redirect install.
    assign static_ok = 32'(index_reg) < 32'(STATIC_LIM);
    assign slot_sel  = inv_found_reg ? inv_idx_reg :
                       exp_found_reg ? exp_idx_reg : best_idx_reg;
    assign tmg_we    = cmd.commit && (((op_reg == OP_WRITE) && static_ok)
                       || ((op_reg == OP_REDIRECT) && HAS_DYN));
    assign exp_we    = cmd.commit && (op_reg == OP_REDIRECT) && HAS_DYN;
    assign w_addr    = (op_reg == OP_WRITE) ? index_reg[IDX_W-1:0] : slot_sel;
    assign tmg_wdata = (op_reg == OP_WRITE) ? {target_reg, mask_reg, gw_reg}
                                            : {target_reg, ALL_ONES, gw_reg};
    assign exp_wdata = now_reg + div_quot;

    // Route memories, one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (tmg_we)
        begin
            tmg_mem[w_addr] <= tmg_wdata;
        end
        if (exp_we)
        begin
            exp_mem[w_addr] <= exp_wdata;
        end
        if (cmd.rd_en)
        begin
            tmg_rd_reg <= tmg_mem[scan_idx];
            exp_rd_reg <= exp_mem[scan_idx];
            wr_rd_reg  <= written_reg[scan_idx];
            rd_idx_reg <= scan_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    // Entry flags and the per-request scan results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                entry_valid_reg[i] <= (i < STATIC_ENTRIES);
            end
            written_reg   <= '0;
            hit_reg       <= 1'b0;
            hop_reg       <= '0;
            inv_found_reg <= 1'b0;
            exp_found_reg <= 1'b0;
            inv_idx_reg   <= '0;
            exp_idx_reg   <= '0;
            best_idx_reg  <= IDX_DYN;
            best_diff_reg <= DIFF_INIT;
        end
        else
        begin
            if (cmd.capture)
            begin
                hit_reg       <= 1'b0;
                inv_found_reg <= 1'b0;
                exp_found_reg <= 1'b0;
                best_idx_reg  <= IDX_DYN;
                best_diff_reg <= DIFF_INIT;
            end

            // The first match from the top of the table decides the next hop.
            if (hit_now)
            begin
                hit_reg <= 1'b1;
                hop_reg <= (ent_gw == '0) ? dest_reg : ent_gw;
            end

            // Redirect: first free entry, else first expired, else nearest to expiry.
            if (rd_vld_reg && op_reg == OP_REDIRECT)
            begin
                if (!ent_valid)
                begin
                    if (!inv_found_reg)
                    begin
                        inv_found_reg <= 1'b1;
                        inv_idx_reg   <= rd_idx_reg;
                    end
                end
                else if (expired)
                begin
                    if (!exp_found_reg)
                    begin
                        exp_found_reg <= 1'b1;
                        exp_idx_reg   <= rd_idx_reg;
                    end
                end
                else if (diff < best_diff_reg)
                begin
                    best_diff_reg <= diff;
                    best_idx_reg  <= rd_idx_reg;
                end
            end

            // Tick drops dynamic entries whose time has come.
            if (rd_vld_reg && op_reg == OP_TICK && ent_valid && expired)
            begin
                entry_valid_reg[rd_idx_reg] <= 1'b0;
            end

            if (tmg_we)
            begin
                written_reg[w_addr] <= 1'b1;
            end
            if (exp_we)
            begin
                entry_valid_reg[w_addr] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            next_hop_reg <= (op_reg == OP_LOOKUP) ? (hit_reg ? hop_reg : dest_reg) : '0;
            status_reg   <= (op_reg == OP_WRITE) && !static_ok;
            slot_reg     <= ((op_reg == OP_REDIRECT) && HAS_DYN) ? SLOT_W'(slot_sel) : '0;
        end
    end

    assign next_hop  = next_hop_reg;
    assign status    = status_reg;
    assign slot_used = slot_reg;

endmodule

### design/route_table_with_expiry_core.sv
`timescale 1ns / 1ps
// IPv4 route table with expiring redirect entries.
// Requests enter on the s_ group (s_tvalid, s_tready, s_tdata) and one result per
// request leaves on the m_ group (m_tvalid, m_tready, m_tdata).
// A lookup reads every entry once, one per cycle from the top index down, through
// the single read port of the route memory, then passes a drain state and a finish
// state; the finish state commits the result to the output register and frees the
// input. A static write goes straight to the finish state. A tick scans the dynamic
// entries only, then drains and finishes; with no dynamic entries it goes straight
// to finish, as does a redirect. A redirect reads the dynamic entries while the
// lifetime is scaled to seconds by a two-step reciprocal multiply, and its drain
// state also waits until the multiply is done.
// One request is in work at a time; s_tready is high while the block is idle.
// The result sits in an output register, so a new request is taken while the last
// result still waits; if the receiver stalls, the next result waits in the block
// until the register frees, and no request is taken meanwhile.
// After reset the static entries are valid and read as all zero (match every
// address, deliver directly), the dynamic entries are free, and no result is held.
// There is no clearing pass.

module route_table_with_expiry_core
    import rtwe_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 8,
    parameter int STATIC_ENTRIES   = 4,
    parameter int TICKS_PER_SECOND = 1000
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode, dest_addr, entry_index, route_target, route_mask, gateway_addr,
    // lifetime_ms, now_seconds, then six zero bits
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_hop, status, slot_used, then four zero bits
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    ctrl_cmd_t         cmd;
    logic [IDX_W-1:0]  scan_idx;
    logic              div_busy;
    op_t               opcode;
    logic [ADDR_W-1:0] next_hop;
    logic              status;
    logic [SLOT_W-1:0] slot_used;

    assign opcode = op_t'(s_tdata[S_OPCODE_LSB +: 2]);

    // Sequencer.
    rtwe_ctrl #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .STATIC_ENTRIES (STATIC_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (opcode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .div_busy (div_busy),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    // Tables, divider and result register.
    rtwe_dp #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .STATIC_ENTRIES   (STATIC_ENTRIES),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .scan_idx     (scan_idx),
        .opcode       (opcode),
        .dest_addr    (s_tdata[S_DEST_LSB +: ADDR_W]),
        .entry_index  (s_tdata[S_INDEX_LSB +: EIDX_W]),
        .route_target (s_tdata[S_TARGET_LSB +: ADDR_W]),
        .route_mask   (s_tdata[S_MASK_LSB +: ADDR_W]),
        .gateway_addr (s_tdata[S_GW_LSB +: ADDR_W]),
        .lifetime_ms  (s_tdata[S_LIFE_LSB +: ADDR_W]),
        .now_seconds  (s_tdata[S_NOW_LSB +: ADDR_W]),
        .div_busy     (div_busy),
        .next_hop     (next_hop),
        .status       (status),
        .slot_used    (slot_used)
    );

    assign m_tdata = {{(M_TDATA_W - M_PAD_LSB){1'b0}}, slot_used, status, next_hop};

endmodule

### design/rtwe_checker.sv
`timescale 1ns / 1ps
`include "route_table_with_expiry_core_assert.svh"

module rtwe_checker
    import rtwe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    `RTWE_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Only one request is in work at a time.
    `RTWE_ASSERT(a_one_request, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // A rejected static write carries no next hop and no slot.
    `RTWE_ASSERT(a_error_clean, m_tvalid && m_tdata[M_STATUS_BIT] |-> m_tdata[M_HOP_LSB +: ADDR_W] == '0 && m_tdata[M_SLOT_LSB +: SLOT_W] == '0, "error result not clean")

    // The padding of the result stays zero.
    `RTWE_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[M_TDATA_W-1:M_PAD_LSB] == '0, "result padding set")

endmodule

bind route_table_with_expiry_core rtwe_checker u_rtwe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
